/* rtl/core/ssm_pkg.sv */
// shared constants, codes and controller/datapath interface types
// for the skid steer mixer; no dependencies
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int FUNC_W     = 2;
    localparam int SPEED_W    = 16;
    localparam int MAG_W      = 17;
    localparam int FRAC_W     = 14;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int VAL_W      = 16;
    localparam int CALC_W     = 18;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int PAD_W      = OUT_DATA_W - 2 * VAL_W - 2;

    localparam int DIV_NUM_W  = 44;
    localparam int DIV_DEN_W  = 30;
    localparam int DIV_CNT_W  = 6;

    localparam logic [FUNC_W-1:0] FUNC_DRIVE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BUTTON = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP  = 8'd1;

    localparam logic [CFG_W-1:0] MAX_SPEED_RST = 15'd640;
    localparam logic [CFG_W-1:0] MAX_STEP_RST  = 15'd246;

    localparam logic [1:0] MODE_REAR  = 2'd0;
    localparam logic [1:0] MODE_FRONT = 2'd1;
    localparam logic [1:0] MODE_BOTH  = 2'd2;

    localparam logic [DIV_DEN_W-1:0] ONE_Q14 = 30'd16384;

    localparam logic [1:0] SRC_MOVE_RAW   = 2'd0;
    localparam logic [1:0] SRC_ROT_RAW    = 2'd1;
    localparam logic [1:0] SRC_MOVE_SCALE = 2'd2;
    localparam logic [1:0] SRC_ROT_SCALE  = 2'd3;

    typedef struct packed {
        logic       load_drive;
        logic       set_axle;
        logic       tick;
        logic       div_start;
        logic [1:0] div_src;
        logic       wr_move;
        logic       wr_rot;
        logic       latch_s;
        logic       mix;
    } ssm_cmd_t;

    typedef struct packed {
        logic div_done;
        logic need_scale;
        logic out_blocked;
    } ssm_status_t;

endpackage

/* rtl/core/ssm_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// uses ssm_pkg widths
`timescale 1ns / 1ps

module ssm_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ssm_pkg::DIV_NUM_W-1:0] numer,
    input  logic [ssm_pkg::DIV_DEN_W-1:0] denom,
    output logic                          done,
    output logic [ssm_pkg::DIV_NUM_W-1:0] quot
);

    localparam logic [ssm_pkg::DIV_CNT_W-1:0] CNT_INIT =
        ssm_pkg::DIV_CNT_W'(ssm_pkg::DIV_NUM_W - 1);

    logic [ssm_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [ssm_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [ssm_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [ssm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ssm_pkg::DIV_DEN_W:0]   trial;
    logic [ssm_pkg::DIV_DEN_W:0]   diff;
    logic                          fits;

    assign trial = {rem_reg, num_reg[ssm_pkg::DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
            cnt_next  = CNT_INIT;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[ssm_pkg::DIV_NUM_W-2:0], fits};
            rem_next = fits ? diff[ssm_pkg::DIV_DEN_W-1:0]
                            : trial[ssm_pkg::DIV_DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

/* rtl/core/ssm_ctrl.sv */
// sequencing state machine for drive scaling, mixing and input acceptance
// uses ssm_pkg command and status types
`timescale 1ns / 1ps

module ssm_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ssm_pkg::FUNC_W-1:0] s_tuser,
    input  ssm_pkg::ssm_status_t       sts,
    output ssm_pkg::ssm_cmd_t          cmd
);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_START_MOVE = 4'd1;
    localparam logic [3:0] ST_WAIT_MOVE  = 4'd2;
    localparam logic [3:0] ST_WAIT_ROT   = 4'd3;
    localparam logic [3:0] ST_CHECK      = 4'd4;
    localparam logic [3:0] ST_SCALE_GO   = 4'd5;
    localparam logic [3:0] ST_WAIT_SM    = 4'd6;
    localparam logic [3:0] ST_WAIT_SR    = 4'd7;
    localparam logic [3:0] ST_MIX        = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE) &&
                      ((s_tuser != ssm_pkg::FUNC_TICK) || !sts.out_blocked);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        ssm_pkg::FUNC_DRIVE: begin
                            cmd.load_drive = 1'b1;
                            state_next     = ST_START_MOVE;
                        end
                        ssm_pkg::FUNC_BUTTON: cmd.set_axle = 1'b1;
                        ssm_pkg::FUNC_TICK:   cmd.tick     = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_START_MOVE: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = ssm_pkg::SRC_MOVE_RAW;
                state_next    = ST_WAIT_MOVE;
            end
            ST_WAIT_MOVE: begin
                if (sts.div_done) begin
                    cmd.wr_move   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_src   = ssm_pkg::SRC_ROT_RAW;
                    state_next    = ST_WAIT_ROT;
                end
            end
            ST_WAIT_ROT: begin
                cmd.div_src = ssm_pkg::SRC_ROT_RAW;
                if (sts.div_done) begin
                    cmd.wr_rot = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.latch_s = 1'b1;
                state_next  = sts.need_scale ? ST_SCALE_GO : ST_MIX;
            end
            ST_SCALE_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = ssm_pkg::SRC_MOVE_SCALE;
                state_next    = ST_WAIT_SM;
            end
            ST_WAIT_SM: begin
                cmd.div_src = ssm_pkg::SRC_MOVE_SCALE;
                if (sts.div_done) begin
                    cmd.wr_move   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_src   = ssm_pkg::SRC_ROT_SCALE;
                    state_next    = ST_WAIT_SR;
                end
            end
            ST_WAIT_SR: begin
                cmd.div_src = ssm_pkg::SRC_ROT_SCALE;
                if (sts.div_done) begin
                    cmd.wr_rot = 1'b1;
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/ssm_datapath.sv */
// configuration, scaling, arcade mixing, slew limiting and output register
// uses ssm_pkg and instantiates ssm_div
`timescale 1ns / 1ps

module ssm_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ssm_pkg::ssm_cmd_t               cmd,
    output ssm_pkg::ssm_status_t            sts,
    input  logic [ssm_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ssm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = ssm_pkg::CALC_W;

    logic [ssm_pkg::CFG_W-1:0]     max_speed_reg, max_step_reg;
    logic [ssm_pkg::CFG_W-1:0]     speed_eff;
    logic [ssm_pkg::MAG_W-1:0]     lin_mag_reg, turn_mag_reg;
    logic                          move_neg_reg, rot_neg_reg;
    logic [ssm_pkg::DIV_DEN_W-1:0] move_mag_reg, rot_mag_reg, s_reg;
    logic [ssm_pkg::DIV_DEN_W-1:0] s_max;
    logic signed [ssm_pkg::VAL_W-1:0] left_target_reg, right_target_reg;
    logic signed [ssm_pkg::VAL_W-1:0] left_last_reg, right_last_reg;
    logic signed [ssm_pkg::VAL_W-1:0] left_new, right_new;
    logic [1:0]                    axle_mode_reg;
    logic                          m_tvalid_reg;
    logic [ssm_pkg::VAL_W-1:0]     out_left_reg, out_right_reg;
    logic                          out_front_reg, out_back_reg;

    logic [ssm_pkg::SPEED_W-1:0]   in_lin, in_turn;
    logic [ssm_pkg::MAG_W-1:0]     lin_ext, turn_ext;
    logic                          in_rear, in_front;

    logic [ssm_pkg::DIV_NUM_W-1:0] div_numer, div_quot;
    logic [ssm_pkg::DIV_DEN_W-1:0] div_denom;
    logic                          div_done;

    logic signed [CW-1:0] mv, rv, mix_l, mix_r;

    assign in_lin   = s_tdata[15:0];
    assign in_turn  = s_tdata[31:16];
    assign in_rear  = s_tdata[32];
    assign in_front = s_tdata[33];
    assign lin_ext  = {in_lin[15], in_lin};
    assign turn_ext = {in_turn[15], in_turn};

    assign speed_eff = (max_speed_reg == '0) ? ssm_pkg::CFG_W'(1) : max_speed_reg;
    assign s_max     = (move_mag_reg > rot_mag_reg) ? move_mag_reg : rot_mag_reg;

    always_comb begin
        unique case (cmd.div_src)
            ssm_pkg::SRC_MOVE_RAW: begin
                div_numer = ssm_pkg::DIV_NUM_W'({lin_mag_reg, {ssm_pkg::FRAC_W{1'b0}}});
                div_denom = ssm_pkg::DIV_DEN_W'(speed_eff);
            end
            ssm_pkg::SRC_ROT_RAW: begin
                div_numer = ssm_pkg::DIV_NUM_W'({turn_mag_reg, {ssm_pkg::FRAC_W{1'b0}}});
                div_denom = ssm_pkg::DIV_DEN_W'(speed_eff);
            end
            ssm_pkg::SRC_MOVE_SCALE: begin
                div_numer = {move_mag_reg, {ssm_pkg::FRAC_W{1'b0}}};
                div_denom = s_reg;
            end
            default: begin
                div_numer = {rot_mag_reg, {ssm_pkg::FRAC_W{1'b0}}};
                div_denom = s_reg;
            end
        endcase
    end

    ssm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .done    (div_done),
        .quot    (div_quot)
    );

    function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        smax = (a > b) ? a : b;
    endfunction

    function automatic logic signed [ssm_pkg::VAL_W-1:0] slew(
        input logic signed [ssm_pkg::VAL_W-1:0] last,
        input logic signed [ssm_pkg::VAL_W-1:0] target,
        input logic [ssm_pkg::CFG_W-1:0]        step);
        logic signed [CW-1:0] d, ad, m, lx, res;
        lx  = CW'(last);
        d   = CW'(target) - lx;
        ad  = (d < 0) ? -d : d;
        m   = $signed(CW'(step));
        res = (ad <= m) ? CW'(target) : ((d > 0) ? lx + m : lx - m);
        slew = res[ssm_pkg::VAL_W-1:0];
    endfunction

    // signed move and rotation from magnitude and sign, both within one
    always_comb begin
        mv = $signed({3'b000, move_mag_reg[14:0]});
        rv = $signed({3'b000, rot_mag_reg[14:0]});
        if (move_neg_reg) mv = -mv;
        if (rot_neg_reg)  rv = -rv;
        if (mv > 0) begin
            if (rv > 0) begin
                mix_l = mv - rv;
                mix_r = smax(mv, rv);
            end else begin
                mix_l = smax(mv, -rv);
                mix_r = mv + rv;
            end
        end else begin
            if (rv > 0) begin
                mix_l = -smax(-mv, rv);
                mix_r = mv + rv;
            end else begin
                mix_l = mv - rv;
                mix_r = -smax(-mv, -rv);
            end
        end
    end

    assign left_new  = slew(left_last_reg, left_target_reg, max_step_reg);
    assign right_new = slew(right_last_reg, right_target_reg, max_step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg    <= ssm_pkg::MAX_SPEED_RST;
            max_step_reg     <= ssm_pkg::MAX_STEP_RST;
            left_target_reg  <= '0;
            right_target_reg <= '0;
            left_last_reg    <= '0;
            right_last_reg   <= '0;
            axle_mode_reg    <= ssm_pkg::MODE_BOTH;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == ssm_pkg::CFG_MAX_SPEED)
                    max_speed_reg <= cfg_data[ssm_pkg::CFG_W-1:0];
                else if (cfg_index == ssm_pkg::CFG_MAX_STEP)
                    max_step_reg <= cfg_data[ssm_pkg::CFG_W-1:0];
            end
            if (cmd.mix) begin
                left_target_reg  <= mix_l[ssm_pkg::VAL_W-1:0];
                right_target_reg <= mix_r[ssm_pkg::VAL_W-1:0];
            end
            if (cmd.set_axle) begin
                priority if (in_rear)  axle_mode_reg <= ssm_pkg::MODE_REAR;
                else if (in_front)     axle_mode_reg <= ssm_pkg::MODE_FRONT;
                else                   axle_mode_reg <= ssm_pkg::MODE_BOTH;
            end
            if (cmd.tick) begin
                left_last_reg  <= left_new;
                right_last_reg <= right_new;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (cmd.load_drive) begin
            lin_mag_reg  <= in_lin[15] ? (~lin_ext + 1'b1) : lin_ext;
            turn_mag_reg <= in_turn[15] ? (~turn_ext + 1'b1) : turn_ext;
            move_neg_reg <= in_lin[15];
            rot_neg_reg  <= in_turn[15];
        end
        if (cmd.wr_move) move_mag_reg <= div_quot[ssm_pkg::DIV_DEN_W-1:0];
        if (cmd.wr_rot)  rot_mag_reg  <= div_quot[ssm_pkg::DIV_DEN_W-1:0];
        if (cmd.latch_s) s_reg <= s_max;
        if (cmd.tick) begin
            out_left_reg  <= left_new;
            out_right_reg <= right_new;
            out_front_reg <= axle_mode_reg != ssm_pkg::MODE_REAR;
            out_back_reg  <= axle_mode_reg != ssm_pkg::MODE_FRONT;
        end
    end

    assign sts.div_done    = div_done;
    assign sts.need_scale  = s_max > ssm_pkg::ONE_Q14;
    assign sts.out_blocked = m_tvalid_reg && !m_tready;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{ssm_pkg::PAD_W{1'b0}}, out_back_reg, out_front_reg,
                        out_right_reg, out_left_reg};

endmodule

/* rtl/core/skid_steer_mixer_slew_limit.sv */
// top level of the skid steer arcade mixer with per-side slew limit
// depends on ssm_pkg, ssm_ctrl, ssm_datapath
`timescale 1ns / 1ps

// input stream: s_tuser selects the item kind (drive, button, tick), s_tdata
// carries speeds and buttons. output stream: one transfer per tick with the
// slew-limited left/right values and the front/back axle enables.
// configuration channel: cfg_index 0 is max_speed, 1 is max_step; writes are
// taken every cycle and are meant for idle periods only.
// a drive item is scaled by an iterative divider, one quotient bit per cycle
// over 44 bits; two divisions always run and two more when the larger value
// exceeds one, and no new input item is taken until the drive item is mixed.
// button and tick items leave the block ready for the next item; a tick
// result shows on m_tvalid in the cycle after its transfer.
// the output register frees the input side: drive and button items are taken
// while a result waits, a tick waits for the output register to drain.
// reset restores the register defaults, zero targets and last values, both
// axles enabled and an empty output.
module skid_steer_mixer_slew_limit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // linear_speed, turn_rate, rear_button, front_button, zero pad
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // left_value, right_value, drive_front, drive_back, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ssm_pkg::ssm_cmd_t    cmd;
    ssm_pkg::ssm_status_t sts;

    ssm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* rtl/core/ssm_checker.sv */
// port-level checks for skid_steer_mixer_slew_limit, bound to the top level
// depends on ssm_pkg
`timescale 1ns / 1ps

module ssm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a new result only follows a tick transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == ssm_pkg::FUNC_TICK))
        else $error("result without tick");

    // drive and button items never produce a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != ssm_pkg::FUNC_TICK && !m_tvalid |=> !m_tvalid)
        else $error("result from non-tick item");

endmodule

bind skid_steer_mixer_slew_limit ssm_checker u_ssm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/ssm_wheel_checker.sv */
`timescale 1ns / 1ps
// checker for the skid steer mixer: watches the input, result and register channels,
// predicts each tick's wheel values and compares them with what the block sends
// depends on ssm_pkg
module ssm_wheel_checker
    import ssm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);

    typedef struct packed {
        logic signed [VAL_W-1:0] left;
        logic signed [VAL_W-1:0] right;
        logic                    front;
        logic                    back;
    } wheel_cmd_t;

    wheel_cmd_t wheel_q[$];
    wheel_cmd_t want, got;

    logic [CFG_W-1:0]        speed_limit, step_limit;
    logic signed [VAL_W-1:0] left_goal, right_goal, left_now, right_now;
    logic [1:0]              axle_sel;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

    // arcade mix of linear and turn commands, normalized here, into side targets
    task automatic mix_targets(input logic signed [15:0] lin, input logic signed [15:0] turn);
        longint div, mv, rt, s, l, r;
        div = (speed_limit == 0) ? 1 : longint'(speed_limit);
        mv = (longint'(lin) * 16384) / div;
        rt = (longint'(turn) * 16384) / div;
        s = (mv < 0) ? -mv : mv;
        if (((rt < 0) ? -rt : rt) > s)
            s = (rt < 0) ? -rt : rt;
        if (s > 16384) begin
            mv = (mv * 16384) / s;
            rt = (rt * 16384) / s;
        end
        if (mv > 0) begin
            if (rt > 0) begin
                l = mv - rt;
                r = (mv > rt) ? mv : rt;
            end else begin
                l = (mv > -rt) ? mv : -rt;
                r = mv + rt;
            end
        end else begin
            if (rt > 0) begin
                l = (-mv > rt) ? mv : -rt;
                r = mv + rt;
            end else begin
                l = mv - rt;
                r = (-mv > -rt) ? mv : rt;
            end
        end
        left_goal  = l[VAL_W-1:0];
        right_goal = r[VAL_W-1:0];
    endtask

    function automatic logic signed [VAL_W-1:0] slew_toward(
        input logic signed [VAL_W-1:0] now,
        input logic signed [VAL_W-1:0] goal
    );
        longint d, lim, nxt;
        d = longint'(goal) - longint'(now);
        lim = longint'(step_limit);
        if (((d < 0) ? -d : d) <= lim)
            return goal;
        nxt = (d > 0) ? longint'(now) + lim : longint'(now) - lim;
        return nxt[VAL_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit = MAX_SPEED_RST;
            step_limit  = MAX_STEP_RST;
            left_goal   = '0;
            right_goal  = '0;
            left_now    = '0;
            right_now   = '0;
            axle_sel    = MODE_BOTH;
            wheel_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.left  = m_tdata[15:0];
                got.right = m_tdata[31:16];
                got.front = m_tdata[32];
                got.back  = m_tdata[33];
                if (wheel_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected wheel transfer: left %0d right %0d front %0b back %0b",
                                 got.left, got.right, got.front, got.back);
                end else begin
                    want = wheel_q.pop_front();
                    checked_count++;
                    if (got.left !== want.left || got.right !== want.right ||
                        got.front !== want.front || got.back !== want.back) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"wheel mismatch at result %0d: left %0d/%0d right %0d/%0d",
                                      " front %0b/%0b back %0b/%0b (expected/actual)"},
                                     checked_count, want.left, got.left, want.right, got.right,
                                     want.front, got.front, want.back, got.back);
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MAX_SPEED)
                    speed_limit = cfg_data[CFG_W-1:0];
                else if (cfg_index == CFG_MAX_STEP)
                    step_limit = cfg_data[CFG_W-1:0];
            end

            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    FUNC_DRIVE: begin
                        mix_targets(s_tdata[15:0], s_tdata[31:16]);
                    end
                    FUNC_BUTTON: begin
                        if (s_tdata[32])
                            axle_sel = MODE_REAR;
                        else if (s_tdata[33])
                            axle_sel = MODE_FRONT;
                        else
                            axle_sel = MODE_BOTH;
                    end
                    FUNC_TICK: begin
                        left_now  = slew_toward(left_now, left_goal);
                        right_now = slew_toward(right_now, right_goal);
                        want.left  = left_now;
                        want.right = right_now;
                        want.front = (axle_sel != MODE_REAR);
                        want.back  = (axle_sel != MODE_FRONT);
                        wheel_q.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
        pending_count <= wheel_q.size();
    end

endmodule

/* sim/skid_steer_mixer_slew_limit_test.sv */
`timescale 1ns / 1ps
// testbench top for the skid steer mixer: clock, reset, stimulus, idling and verdict
// depends on ssm_pkg, skid_steer_mixer_slew_limit and ssm_wheel_checker
module skid_steer_mixer_slew_limit_test;
    import ssm_pkg::*;

    localparam logic [FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd2;
    localparam int SETTLE_CYCLES = 250;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 170;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid, m_tready;
    logic [39:0] m_tdata;
    logic        cfg_valid, cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    int fail_count, pending_count, checked_count;
    int items_sent, cfg_writes, burst_left, cur_speed, cycle_count;
    bit quiet_tx, steady_rx, hold_req;

    skid_steer_mixer_slew_limit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ssm_wheel_checker wheel_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [39:0] pack_item(input logic [15:0] lin, input logic [15:0] turn,
                                              input logic rear, input logic front);
        return {6'b0, front, rear, turn, lin};
    endfunction

    function automatic logic [15:0] rand_speed();
        int lim;
        lim = (cur_speed < 1) ? 1 : cur_speed;
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            1:       return 16'(int'($urandom_range(0, 4)) - 2);
            2, 3:    return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 2 * lim)) - lim);
        endcase
    endfunction

    // sender works in bursts; valid stays high between items of one burst
    task automatic put_item(input logic [1:0] func, input logic [39:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = (quiet_tx || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_random();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            put_item(FUNC_DRIVE, pack_item(rand_speed(), rand_speed(), 1'($urandom), 1'($urandom)));
        else if (pick < 45)
            put_item(FUNC_BUTTON, pack_item(16'($urandom), 16'($urandom), 1'($urandom),
                                            1'($urandom)));
        else if (pick < 97)
            put_item(FUNC_TICK, pack_item(16'($urandom), 16'($urandom), 1'($urandom),
                                          1'($urandom)));
        else
            put_item(FUNC_UNUSED, pack_item(16'($urandom), 16'($urandom), 1'($urandom),
                                            1'($urandom)));
    endtask

    // wait for every pending result, then let an in-flight drive division finish
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cfg_writes++;
    endtask

    task automatic set_limits(input logic [15:0] speed, input logic [15:0] step);
        write_reg(CFG_MAX_SPEED, speed);
        write_reg(CFG_MAX_STEP, step);
        cur_speed = int'(speed[CFG_W-1:0]);
    endtask

    // receiver: random ready pattern, one long hold-off on request
    initial begin
        int run;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held = 1'b1;
            end
            run = $urandom_range(1, 10);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            if (!steady_rx && $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= FUNC_DRIVE;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        hold_req   = 1'b0;
        quiet_tx   = 1'b0;
        steady_rx  = 1'b0;
        burst_left = 0;
        items_sent = 0;
        cfg_writes = 0;
        cur_speed  = int'(MAX_SPEED_RST);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: all quadrants, rescaling, axle buttons, ignored code
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_DRIVE,  pack_item(16'd640, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_DRIVE,  pack_item(16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_DRIVE,  pack_item(16'h8000, 16'h8000, 1'b0, 1'b0));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_DRIVE,  pack_item(16'd0, 16'h7FFF, 1'b0, 1'b0));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_DRIVE,  pack_item(16'hFFFF, 16'd1, 1'b0, 1'b0));
        put_item(FUNC_BUTTON, pack_item(16'd0, 16'd0, 1'b1, 1'b1));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_BUTTON, pack_item(16'd0, 16'd0, 1'b0, 1'b1));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_BUTTON, pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_BUTTON, pack_item(16'd0, 16'd0, 1'b1, 1'b0));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_UNUSED, pack_item(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        put_item(FUNC_DRIVE,  pack_item(16'h7FFF, 16'h8000, 1'b0, 1'b0));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));
        put_item(FUNC_DRIVE,  pack_item(-16'sd640, 16'd320, 1'b0, 1'b0));
        put_item(FUNC_TICK,   pack_item(16'd0, 16'd0, 1'b0, 1'b0));

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: set_limits(16'd1, 16'd16384);
                    2: set_limits(16'd32767, 16'd0);
                    3: set_limits(16'd0, 16'd1);
                    4: set_limits(16'h8000 | 16'd640, 16'h8000 | 16'd246);
                    5: set_limits(16'($urandom_range(1, 32767)), 16'($urandom_range(0, 16384)));
                    6: begin
                        set_limits(16'd256, 16'd8192);
                        write_reg(CFG_UNMAPPED, 16'($urandom));
                    end
                    default: set_limits(16'($urandom_range(1, 32767)),
                                        16'($urandom_range(0, 16384)));
                endcase
            end
            quiet_tx  = (p == 4);
            steady_rx = (p == 5);
            if (p == 3)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_random();
        end
        drain();

        $display("run covered %0d input transfers over %0d register settings (%0d writes)",
                 items_sent, PHASES, cfg_writes);
        $display("%0d wheel results compared, one %0d-cycle receiver hold-off included",
                 checked_count, HOLD_CYCLES);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ssm_pkg.sv
rtl/core/ssm_div.sv
rtl/core/ssm_ctrl.sv
rtl/core/ssm_datapath.sv
rtl/core/skid_steer_mixer_slew_limit.sv
rtl/core/ssm_checker.sv
sim/ssm_wheel_checker.sv
sim/skid_steer_mixer_slew_limit_test.sv
